// ----- src/cdq_pkg.sv -----
// Shared constants, operation codes and the cell control struct for the deque.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    // one-hot (or all-zero) command broadcast to every cell of the chain
    typedef struct packed {
        logic clear;
        logic ins_front;
        logic ins_rear;
        logic del_front;
        logic del_rear;
    } t_cell_ctrl;

endpackage

// ----- src/cdq_cell.sv -----
// One storage cell of the deque chain; entries sit in order from front (cell 0) to rear.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic              i_left_occ,
    input  logic [DATA_W-1:0] i_right_data,
    input  logic              i_right_occ,
    output logic [DATA_W-1:0] o_data,
    output logic              o_occ,
    output logic              o_rear
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_occ;
    logic              n_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctrl.clear) begin
            n_occ = 1'b0;
        end else if (i_ctrl.ins_front) begin
            // whole row moves one step toward the rear
            n_data = i_left_data;
            n_occ  = i_left_occ;
        end else if (i_ctrl.ins_rear) begin
            // first free cell behind the last occupied one takes the word
            if (!r_occ && i_left_occ) begin
                n_data = i_value;
                n_occ  = 1'b1;
            end
        end else if (i_ctrl.del_front) begin
            n_data = i_right_data;
            n_occ  = i_right_occ;
        end else if (i_ctrl.del_rear) begin
            if (r_occ && !i_right_occ) begin
                n_occ = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_occ  = r_occ;
    assign o_rear = r_occ && !i_right_occ;

endmodule

// ----- src/circular_deque.sv -----
// A result is registered: it is valid in the cycle after its operation transfers in.
// Throughput: one operation per cycle while the result side takes transfers;
//   every operation is one update of the cell chain and the count.
// Input stalls only while a finished result waits on a stalled output.
// Reset (synchronous, active low): deque empty, capacity 16, no result held.
// Writing capacity empties the deque; a write of 0 acts as 1, above 16 as 16.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_empty_res,
    output logic                     o_full_res
);

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ok;
    logic              n_ok;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]  w_occ;
    logic [DEPTH-1:0]  w_rear;
    logic [DATA_W-1:0] w_rear_data;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count >= r_cap);
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl  = '0;
        n_ok    = r_ok;
        n_count = r_count;
        if (i_cfg_we) begin
            w_ctrl.clear = 1'b1;
            n_count      = '0;
        end else if (w_accept) begin
            n_ok = 1'b1;
            case (i_opcode)
                OP_INS_FRONT: begin
                    if (w_full) begin
                        n_ok = 1'b0;
                    end else begin
                        w_ctrl.ins_front = 1'b1;
                        n_count          = r_count + CNT_W'(1);
                    end
                end
                OP_INS_REAR: begin
                    if (w_full) begin
                        n_ok = 1'b0;
                    end else begin
                        w_ctrl.ins_rear = 1'b1;
                        n_count         = r_count + CNT_W'(1);
                    end
                end
                OP_DEL_FRONT: begin
                    if (w_empty) begin
                        n_ok = 1'b0;
                    end else begin
                        w_ctrl.del_front = 1'b1;
                        n_count          = r_count - CNT_W'(1);
                    end
                end
                OP_DEL_REAR: begin
                    if (w_empty) begin
                        n_ok = 1'b0;
                    end else begin
                        w_ctrl.del_rear = 1'b1;
                        n_count         = r_count - CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    n_ok = 1'b1;
                end
                default: begin
                    n_ok = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNT_W'(DEPTH);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left_data;
        logic              w_left_occ;
        logic [DATA_W-1:0] w_right_data;
        logic              w_right_occ;

        if (g == 0) begin : g_head
            assign w_left_data = i_value;
            assign w_left_occ  = 1'b1;
        end else begin : g_body
            assign w_left_data = w_data[g-1];
            assign w_left_occ  = w_occ[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data = '0;
            assign w_right_occ  = 1'b0;
        end else begin : g_inner
            assign w_right_data = w_data[g+1];
            assign w_right_occ  = w_occ[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_left_data  (w_left_data),
            .i_left_occ   (w_left_occ),
            .i_right_data (w_right_data),
            .i_right_occ  (w_right_occ),
            .o_data       (w_data[g]),
            .o_occ        (w_occ[g]),
            .o_rear       (w_rear[g])
        );
    end

    // at most one cell flags itself as the rear
    always_comb begin
        w_rear_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear_data = w_rear_data | (w_rear[k] ? w_data[k] : '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_front_value = w_occ[0] ? w_data[0] : '1;
    assign o_rear_value  = w_occ[0] ? w_rear_data : '1;
    assign o_entry_count = r_count;
    assign o_empty_res   = w_empty;
    assign o_full_res    = w_full;

`ifndef SYNTH
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == 32'(r_count))
        else $error("entry count disagrees with occupied cells");

    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ + DEPTH'(1)) & w_occ) == '0)
        else $error("occupied cells not packed at the front");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_rear_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_rear))
        else $error("more than one rear cell");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we && w_full
            && (i_opcode == OP_INS_FRONT || i_opcode == OP_INS_REAR))
        |=> (!r_ok && $stable(r_count)))
        else $error("insert into full deque not refused");
`endif

endmodule

// ----- bench/tb_circular_deque.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque: directed table, then random traffic with idling.
module tb_circular_deque
    import cdq_pkg::*;
();

    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
    localparam int HOLD_LEN    = 60;
    localparam int N_PHASES    = 7;

    typedef enum logic [2:0] {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_HOLD
    } t_idle_mode;

    typedef enum logic { ROW_OP, ROW_CAP } t_row_kind;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic [CNT_W-1:0]         entry_count;
        logic                     empty_res;
        logic                     full_res;
    } t_deque_res;

    typedef struct {
        t_row_kind                kind;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;     // capacity data on ROW_CAP rows
        logic                     has_lit;
        t_deque_res               lit;
    } t_stim_row;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CNT_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic [OP_W-1:0]          i_opcode   = OP_QUERY;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_rear_value;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_empty_res;
    logic                     o_full_res;

    // typed expectation travels with the transfer it belongs to
    logic       row_has_lit = 1'b0;
    t_deque_res row_lit     = '0;

    // deque predictor state
    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    logic [3:0]               front_ix;
    logic [3:0]               rear_ix;
    logic [CNT_W-1:0]         held_n;
    logic [CNT_W-1:0]         cap_now;

    t_deque_res pending_results [$];
    t_stim_row  stim_rows [$];

    t_idle_mode rx_mode      = IDLE_NONE;
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    int         hold_cnt     = 0;

    int err_count           = 0;
    int ops_done            = 0;
    int refusals            = 0;
    int cap_writes          = 0;
    int backpressure_cycles = 0;

    int               phase_len  [N_PHASES] = '{80, 75, 60, 75, 60, 50, 50};
    logic [CNT_W-1:0] phase_cap  [N_PHASES] = '{5'd16, 5'd7, 5'd1, 5'd4, 5'd16, 5'd11,
                                                5'd16};
    t_idle_mode       phase_mode [N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                IDLE_BOTH, IDLE_HOLD, IDLE_SENDER,
                                                IDLE_RECEIVER};

    circular_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_entry_count (o_entry_count),
        .o_empty_res   (o_empty_res),
        .o_full_res    (o_full_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [3:0] ring_up(input logic [3:0] ix);
        return (int'(ix) + 1 >= int'(cap_now)) ? 4'd0 : ix + 4'd1;
    endfunction

    function automatic logic [3:0] ring_down(input logic [3:0] ix);
        return (ix == 4'd0) ? 4'(cap_now - 1) : ix - 4'd1;
    endfunction

    // capacity write saturates to 1..DEPTH and empties the deque
    function automatic void set_capacity(input logic [CNT_W-1:0] data);
        if (data == 0)
            cap_now = CNT_W'(1);
        else if (int'(data) > DEPTH)
            cap_now = CNT_W'(DEPTH);
        else
            cap_now = data;
        front_ix = 4'd0;
        rear_ix  = 4'(cap_now - 1);
        held_n   = '0;
    endfunction

    function automatic t_deque_res apply_deque_op(input logic [OP_W-1:0] op,
                                                  input logic signed [DATA_W-1:0] word);
        t_deque_res r;
        logic       full;
        logic       empty;
        full  = (held_n >= cap_now);
        empty = (held_n == 0);
        r.ok  = 1'b1;
        case (op)
            OP_INS_FRONT: begin
                if (full) begin
                    r.ok = 1'b0;
                end else begin
                    front_ix = ring_down(front_ix);
                    ring_mem[front_ix] = word;
                    held_n++;
                end
            end
            OP_INS_REAR: begin
                if (full) begin
                    r.ok = 1'b0;
                end else begin
                    rear_ix = ring_up(rear_ix);
                    ring_mem[rear_ix] = word;
                    held_n++;
                end
            end
            OP_DEL_FRONT: begin
                if (empty) begin
                    r.ok = 1'b0;
                end else begin
                    front_ix = ring_up(front_ix);
                    held_n--;
                end
            end
            OP_DEL_REAR: begin
                if (empty) begin
                    r.ok = 1'b0;
                end else begin
                    rear_ix = ring_down(rear_ix);
                    held_n--;
                end
            end
            default: ;  // query and spare codes leave the deque alone
        endcase
        r.entry_count = held_n;
        r.empty_res   = (held_n == 0);
        r.full_res    = (held_n >= cap_now);
        r.front_value = r.empty_res ? -32'sd1 : ring_mem[front_ix];
        r.rear_value  = r.empty_res ? -32'sd1 : ring_mem[rear_ix];
        return r;
    endfunction

    function automatic t_deque_res res_lit(input logic ok, input logic signed [DATA_W-1:0] fv,
                                           input logic signed [DATA_W-1:0] rv,
                                           input logic [CNT_W-1:0] cnt, input logic empty,
                                           input logic full);
        t_deque_res r;
        r.ok          = ok;
        r.front_value = fv;
        r.rear_value  = rv;
        r.entry_count = cnt;
        r.empty_res   = empty;
        r.full_res    = full;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // result side: random stall, or one long hold while the sender keeps pushing
    always @(posedge i_clk) begin
        if (rx_mode == IDLE_HOLD && hold_cnt < HOLD_LEN) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // monitor: checks result transfers, predicts on operation transfers
    always @(posedge i_clk) begin
        t_deque_res want;
        if (!i_rst_n) begin
            set_capacity(CNT_W'(DEPTH));
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result transfer with nothing expected", $time);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("ok", DATA_W'(want.ok), DATA_W'(o_ok));
                    compare_field("front_value", want.front_value, o_front_value);
                    compare_field("rear_value", want.rear_value, o_rear_value);
                    compare_field("entry_count", DATA_W'(want.entry_count),
                                  DATA_W'(o_entry_count));
                    compare_field("empty_res", DATA_W'(want.empty_res), DATA_W'(o_empty_res));
                    compare_field("full_res", DATA_W'(want.full_res), DATA_W'(o_full_res));
                end
            end
            if (i_cfg_we) begin
                set_capacity(i_cfg_data);
                cap_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                want = apply_deque_op(i_opcode, i_value);
                if (row_has_lit)
                    want = row_lit;
                pending_results.push_back(want);
                ops_done++;
                if (!want.ok)
                    refusals++;
            end
            if (i_in_valid && o_in_stall)
                backpressure_cycles++;
        end
    end

    task automatic set_mode(input t_idle_mode m);
        rx_mode      = m;
        tx_idle_pct  = (m == IDLE_SENDER) ? 60 : (m == IDLE_BOTH) ? 10 : 0;
        rx_stall_pct = (m == IDLE_RECEIVER) ? 60 : (m == IDLE_BOTH) ? 10 : 0;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] word,
                           input logic has_lit, input t_deque_res lit);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_value     <= word;
        row_has_lit <= has_lit;
        row_lit     <= lit;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && !o_in_stall));
    endtask

    // only with the deque idle: every result out, pipeline drained
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] word, input logic has_lit,
                           input t_deque_res lit);
        t_stim_row r;
        r.kind    = kind;
        r.op      = op;
        r.value   = word;
        r.has_lit = has_lit;
        r.lit     = lit;
        stim_rows.push_back(r);
    endtask

    initial begin
        #400000;
        $display("%0t: run timed out", $time);
        $display("[circular_deque] ERROR");
        $finish;
    end

    initial begin
        t_deque_res               empty_ok;
        t_deque_res               empty_no;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] word;
        logic [CNT_W-1:0]         cap;
        int                       bias;
        int                       chunk;

        empty_ok = res_lit(1'b1, -32'sd1, -32'sd1, 5'd0, 1'b1, 1'b0);
        empty_no = res_lit(1'b0, -32'sd1, -32'sd1, 5'd0, 1'b1, 1'b0);

        // fresh after reset: empty, deletes refused, spare codes act as query
        add_row(ROW_OP, OP_QUERY,     32'sd0, 1'b1, empty_ok);
        add_row(ROW_OP, OP_DEL_FRONT, 32'sd0, 1'b1, empty_no);
        add_row(ROW_OP, OP_DEL_REAR,  32'sd0, 1'b1, empty_no);
        add_row(ROW_OP, OP_RSVD_LO,   32'sd0, 1'b1, empty_ok);
        add_row(ROW_OP, OP_RSVD_HI,   32'sd0, 1'b1, empty_ok);
        // capacity 0 saturates to 1
        add_row(ROW_CAP, OP_QUERY, 32'sd0, 1'b0, '0);
        add_row(ROW_OP, OP_INS_REAR, 32'sh7FFF_FFFF, 1'b1,
                res_lit(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1, 1'b0, 1'b1));
        add_row(ROW_OP, OP_INS_FRONT, 32'sh8000_0000, 1'b1,
                res_lit(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1, 1'b0, 1'b1));
        add_row(ROW_OP, OP_INS_REAR, 32'sd0, 1'b1,
                res_lit(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1, 1'b0, 1'b1));
        add_row(ROW_OP, OP_DEL_FRONT, 32'sd0, 1'b1, empty_ok);
        add_row(ROW_OP, OP_INS_FRONT, 32'sh8000_0000, 1'b1,
                res_lit(1'b1, 32'sh8000_0000, 32'sh8000_0000, 5'd1, 1'b0, 1'b1));
        add_row(ROW_OP, OP_DEL_REAR, 32'sd0, 1'b1, empty_ok);
        // capacity 31 saturates to DEPTH; a held -1 looks like the empty marker
        add_row(ROW_CAP, OP_QUERY, 32'sd31, 1'b0, '0);
        add_row(ROW_OP, OP_INS_FRONT, -32'sd1, 1'b1,
                res_lit(1'b1, -32'sd1, -32'sd1, 5'd1, 1'b0, 1'b0));
        add_row(ROW_OP, OP_DEL_FRONT, 32'sd0, 1'b1, empty_ok);
        // small ring: fill, refuse, wrap both ends, drain
        add_row(ROW_CAP, OP_QUERY, 32'sd3, 1'b0, '0);
        add_row(ROW_OP, OP_INS_REAR,  32'sd1,          1'b0, '0);
        add_row(ROW_OP, OP_INS_FRONT, 32'sh5555_5555,  1'b0, '0);
        add_row(ROW_OP, OP_INS_FRONT, 32'shAAAA_AAAA,  1'b0, '0);
        add_row(ROW_OP, OP_INS_REAR,  32'sd9,          1'b0, '0);
        add_row(ROW_OP, OP_DEL_REAR,  32'sd0,          1'b0, '0);
        add_row(ROW_OP, OP_INS_REAR,  32'sh7FFF_FFFF,  1'b0, '0);
        add_row(ROW_OP, OP_DEL_FRONT, 32'sd0,          1'b0, '0);
        add_row(ROW_OP, OP_DEL_FRONT, 32'sd0,          1'b0, '0);
        add_row(ROW_OP, OP_QUERY,     32'sd0,          1'b0, '0);
        add_row(ROW_OP, OP_DEL_REAR,  32'sd0,          1'b0, '0);
        add_row(ROW_OP, OP_DEL_REAR,  32'sd0,          1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(IDLE_NONE);
        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_CAP)
                write_capacity(stim_rows[k].value[CNT_W-1:0]);
            else
                send_op(stim_rows[k].op, stim_rows[k].value, stim_rows[k].has_lit,
                        stim_rows[k].lit);
        end

        // random traffic: alternating fill and drain tides so full and empty recur
        bias = 25;
        for (int p = 0; p < N_PHASES; p++) begin
            cap = phase_cap[p];
            if (p == N_PHASES - 1)
                cap = CNT_W'($urandom_range(2, DEPTH - 1));
            write_capacity(cap);
            set_mode(phase_mode[p]);
            chunk = 2 * int'(cap) + 2;
            for (int k = 0; k < phase_len[p]; k++) begin
                if (k % chunk == 0)
                    bias = (bias == 80) ? 25 : 80;
                if ($urandom_range(99) < 8)
                    op = OP_W'($urandom_range(OP_RSVD_HI, OP_QUERY));
                else if ($urandom_range(99) < bias)
                    op = $urandom_range(1) ? OP_INS_REAR : OP_INS_FRONT;
                else
                    op = $urandom_range(1) ? OP_DEL_REAR : OP_DEL_FRONT;
                case ($urandom_range(7))
                    0:       word = 32'sh8000_0000;
                    1:       word = 32'sh7FFF_FFFF;
                    2:       word = -32'sd1;
                    3:       word = 32'sd0;
                    default: word = $urandom;
                endcase
                send_op(op, word, 1'b0, '0);
            end
        end

        set_mode(IDLE_NONE);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d deque operations (%0d refused) across %0d capacity settings,",
                 ops_done, refusals, cap_writes);
        $display("with sender gaps, result stalls and %0d cycles of input held off.",
                 backpressure_cycles);
        if (err_count == 0)
            $display("[circular_deque] OK");
        else
            $display("[circular_deque] ERROR");
        $finish;
    end

endmodule
